/* sv/salc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the set associative lru cache lookup
// no dependencies; used by every module of the block

package salc_pkg;

   // width of the block number fields on the ports
   localparam int BLK_W = 16;

   // parameter defaults
   localparam int SETS_DEF       = 16;
   localparam int WAYS_DEF       = 4;
   localparam int BLOCK_BITS_DEF = 16;

   // configuration register fields and reset values
   localparam int SETS_REG_W = 5;
   localparam int WAYS_REG_W = 3;
   localparam logic [SETS_REG_W-1:0] SETS_REG_RST = 5'd16;
   localparam logic [WAYS_REG_W-1:0] WAYS_REG_RST = 3'd4;

   // register index, taken from paddr[2]
   localparam logic REG_SETS = 1'b0;
   localparam logic REG_WAYS = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture block number and start remainder unit
      logic mem_read;   // read the selected set row
      logic commit;     // write the updated row and load the result word
   } salc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_busy;   // remainder unit still stepping
      logic out_busy;   // result register holds a word that is stalled
   } salc_status_type;

endpackage

/* sv/set_assoc_lru_cache_lookup.sv */
`timescale 1ns / 1ps
// Set associative cache lookup with per-set lru ranks. Each accepted word is a
// block number; the block reports hit or miss, the way used and any evicted
// block, one result word per request word, in order. One word is worked at a
// time, in steps: the bit-serial remainder unit forms the set index (block
// number modulo the set count), the controller sees the remainder unit done,
// the set row memory is read into a register, and the row is updated while the
// result is loaded. The next word is accepted after the controller returns to
// idle. The result sits in an output register, so the next word can be accepted
// while it waits; a stalled result holds off only the row update of the
// following word. Reset takes effect with no clearing pass: a per-set flag marks
// rows written since reset. Registers at paddr 0 (sets in use) and 4 (ways in
// use) must be written by the user only while the block is idle; the block
// itself does not enforce this. Zero acts as one and values above the
// configured size saturate.
// depends on salc_pkg, salc_ctrl and salc_dpath

module set_assoc_lru_cache_lookup #(
   parameter int SETS       = salc_pkg::SETS_DEF,
   parameter int WAYS       = salc_pkg::WAYS_DEF,
   parameter int BLOCK_BITS = salc_pkg::BLOCK_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [salc_pkg::BLK_W-1:0]  req_block_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_way_used,
   output logic                        rsp_evicted_valid,
   output logic [salc_pkg::BLK_W-1:0]  rsp_evicted_block,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import salc_pkg::*;

   localparam int SET_CNT_W = $clog2(SETS + 1);
   localparam int WAY_CNT_W = $clog2(WAYS + 1);

   logic [SETS_REG_W-1:0] sets_ff;
   logic [WAYS_REG_W-1:0] ways_ff;
   logic [SET_CNT_W-1:0]  eff_sets;
   logic [WAY_CNT_W-1:0]  eff_ways;
   salc_cmd_type          cmd;
   salc_status_type       status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sets_ff <= SETS_REG_RST;
         ways_ff <= WAYS_REG_RST;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_SETS: sets_ff <= pwdata[SETS_REG_W-1:0];
            REG_WAYS: ways_ff <= pwdata[WAYS_REG_W-1:0];
            default:  ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (paddr[2])
         REG_SETS: prdata = 32'(sets_ff);
         REG_WAYS: prdata = 32'(ways_ff);
         default:  prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // effective counts: zero acts as one, saturate at the built size
   always_comb begin
      if (sets_ff == '0) begin
         eff_sets = SET_CNT_W'(1);
      end else if (32'(sets_ff) > SETS) begin
         eff_sets = SET_CNT_W'(SETS);
      end else begin
         eff_sets = SET_CNT_W'(sets_ff);
      end
      if (ways_ff == '0) begin
         eff_ways = WAY_CNT_W'(1);
      end else if (32'(ways_ff) > WAYS) begin
         eff_ways = WAY_CNT_W'(WAYS);
      end else begin
         eff_ways = WAY_CNT_W'(ways_ff);
      end
   end

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   salc_dpath #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_block_number  (req_block_number),
      .eff_sets          (eff_sets),
      .eff_ways          (eff_ways),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_way_used      (rsp_way_used),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_block (rsp_evicted_block)
   );

endmodule

/* sv/salc_mod.sv */
`timescale 1ns / 1ps
// bit-serial remainder unit: block number modulo the set count, one bit a cycle
// depends on salc_pkg

module salc_mod #(
   parameter int SETS = salc_pkg::SETS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [salc_pkg::BLK_W-1:0]            dividend,
   input  logic [$clog2(SETS+1)-1:0]             divisor,
   output logic                                  busy,
   output logic [$clog2(SETS+1)-1:0]             remainder
);
   import salc_pkg::*;

   localparam int REM_W = $clog2(SETS + 1);
   localparam int CNT_W = $clog2(BLK_W + 1);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] dvs_ff, dvs_in;
   logic [BLK_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W:0]   trial;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, dvd_ff[BLK_W-1]};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(BLK_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = REM_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = REM_W'(trial);
         end
         dvd_in = {dvd_ff[BLK_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // operands carry no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = (cnt_ff != '0);
   assign remainder = rem_ff;

endmodule

/* sv/salc_dpath.sv */
`timescale 1ns / 1ps
// datapath: block register, remainder unit, set row memory, lru update, result word
// depends on salc_pkg and salc_mod

module salc_dpath #(
   parameter int SETS       = salc_pkg::SETS_DEF,
   parameter int WAYS       = salc_pkg::WAYS_DEF,
   parameter int BLOCK_BITS = salc_pkg::BLOCK_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  salc_pkg::salc_cmd_type          cmd,
   output salc_pkg::salc_status_type       status,
   input  logic [salc_pkg::BLK_W-1:0]      req_block_number,
   input  logic [$clog2(SETS+1)-1:0]       eff_sets,
   input  logic [$clog2(WAYS+1)-1:0]       eff_ways,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [1:0]                      rsp_way_used,
   output logic                            rsp_evicted_valid,
   output logic [salc_pkg::BLK_W-1:0]      rsp_evicted_block
);
   import salc_pkg::*;

   localparam int REM_W     = $clog2(SETS + 1);
   localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_CNT_W = $clog2(WAYS + 1);
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_W     = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
   localparam logic [BLK_W-1:0] BLK_MASK =
      (BLOCK_BITS >= BLK_W) ? {BLK_W{1'b1}} : BLK_W'((32'd1 << BLOCK_BITS) - 32'd1);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

   // set row memory, one row per set
   logic [WAYS-1:0][TAG_W-1:0]  tag_mem   [SETS];
   logic [WAYS-1:0][RANK_W-1:0] rank_mem  [SETS];
   logic [WAYS-1:0]             valid_mem [SETS];

   // row written since reset; an untouched row reads as all empty, rank zero
   logic [SETS-1:0] touched_ff;

   logic [BLK_W-1:0]            masked_blk;
   logic [TAG_W-1:0]            blk_ff;
   logic [REM_W-1:0]            rem;
   logic [SET_W-1:0]            set_idx;
   logic                        div_busy;

   logic [WAYS-1:0][TAG_W-1:0]  rd_tag_ff;
   logic [WAYS-1:0][RANK_W-1:0] rd_rank_ff;
   logic [WAYS-1:0]             rd_valid_ff;
   logic                        rd_touch_ff;

   logic [WAYS-1:0][RANK_W-1:0] cur_rank;
   logic [WAYS-1:0]             cur_valid;
   logic [WAYS-1:0]             in_use;
   logic [WAYS-1:0]             hit_vec;
   logic [WAYS-1:0]             empty_vec;
   logic                        found;
   logic                        empty;
   logic [WAY_W-1:0]            hit_way;
   logic [WAY_W-1:0]            empty_way;
   logic [WAY_W-1:0]            vic_way;
   logic [RANK_W-1:0]           oldest;
   logic [WAY_W-1:0]            sel_way;
   logic [RANK_W-1:0]           hit_rank;
   logic [WAYS-1:0][TAG_W-1:0]  new_tag;
   logic [WAYS-1:0][RANK_W-1:0] new_rank;
   logic [WAYS-1:0]             new_valid;
   logic                        ev_valid;
   logic [BLK_W-1:0]            ev_block;
   logic [31:0]                 sel_way_ext;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [1:0]       rsp_way_ff;
   logic             rsp_ev_valid_ff;
   logic [BLK_W-1:0] rsp_ev_block_ff;

   assign masked_blk = req_block_number & BLK_MASK;

   salc_mod #(
      .SETS(SETS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .dividend  (masked_blk),
      .divisor   (eff_sets),
      .busy      (div_busy),
      .remainder (rem)
   );

   assign set_idx = rem[SET_W-1:0];

   // capture the block number
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff <= masked_blk[TAG_W-1:0];
      end
   end

   // row read, registered
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_tag_ff   <= tag_mem[set_idx];
         rd_rank_ff  <= rank_mem[set_idx];
         rd_valid_ff <= valid_mem[set_idx];
         rd_touch_ff <= touched_ff[set_idx];
      end
   end

   // row write
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_idx]   <= new_tag;
         rank_mem[set_idx]  <= new_rank;
         valid_mem[set_idx] <= new_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
      end else if (cmd.commit) begin
         touched_ff[set_idx] <= 1'b1;
      end
   end

   // lookup, victim choice and rank update over the row
   always_comb begin
      cur_valid = rd_touch_ff ? rd_valid_ff : '0;
      cur_rank  = rd_touch_ff ? rd_rank_ff : '0;
      for (int w = 0; w < WAYS; w++) begin
         in_use[w]    = (WAY_CNT_W'(w) < eff_ways);
         hit_vec[w]   = in_use[w] && cur_valid[w] && (rd_tag_ff[w] == blk_ff);
         empty_vec[w] = in_use[w] && !cur_valid[w];
      end
      found     = |hit_vec;
      empty     = |empty_vec;

      // lowest matching way, lowest empty way
      hit_way   = '0;
      empty_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec[w]) begin
            empty_way = WAY_W'(w);
         end
      end

      // oldest rank, lowest way on ties
      oldest  = '0;
      vic_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (in_use[w] && (cur_rank[w] > oldest)) begin
            oldest  = cur_rank[w];
            vic_way = WAY_W'(w);
         end
      end

      if (found) begin
         sel_way = hit_way;
      end else if (empty) begin
         sel_way = empty_way;
      end else begin
         sel_way = vic_way;
      end
      hit_rank = cur_rank[hit_way];

      ev_valid = !found && !empty;
      ev_block = ev_valid ? BLK_W'(rd_tag_ff[vic_way]) : '0;

      // age valid in-use lines younger than the limit, reset the used line
      new_tag   = rd_tag_ff;
      new_rank  = cur_rank;
      new_valid = cur_valid;
      for (int w = 0; w < WAYS; w++) begin
         if (in_use[w]) begin
            if (WAY_W'(w) == sel_way) begin
               new_valid[w] = 1'b1;
               new_tag[w]   = blk_ff;
               new_rank[w]  = '0;
            end else if (cur_valid[w] && (!found || (cur_rank[w] < hit_rank)) &&
                         (cur_rank[w] < RANK_MAX)) begin
               new_rank[w] = cur_rank[w] + RANK_W'(1);
            end
         end
      end
      sel_way_ext = 32'(sel_way);
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff      <= found;
         rsp_way_ff      <= sel_way_ext[1:0];
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_block_ff <= ev_block;
      end
   end

   // status back to the controller
   assign status = '{div_busy: div_busy, out_busy: (rsp_valid_ff && rsp_stall)};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_way_used      = rsp_way_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_block = rsp_ev_block_ff;

endmodule

/* sv/salc_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences accept, remainder, row read and row update for one word
// depends on salc_pkg

module salc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  salc_pkg::salc_status_type  status,
   output salc_pkg::salc_cmd_type     cmd
);
   import salc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_EVAL = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* test/set_assoc_lru_cache_lookup_tb.sv */
`timescale 1ns / 1ps
// testbench for set_assoc_lru_cache_lookup: directed and random block numbers,
// checked word by word against a behavioral cache model with per-set lru ranks
// depends on salc_pkg and set_assoc_lru_cache_lookup

module set_assoc_lru_cache_lookup_tb;

   import salc_pkg::*;

   localparam int SETS  = SETS_DEF;
   localparam int WAYS  = WAYS_DEF;
   localparam int LINES = SETS * WAYS;

   // one result word of the block
   typedef struct packed {
      logic                hit;
      logic [1:0]          way_used;
      logic                evicted_valid;
      logic [BLK_W-1:0]    evicted_block;
   } lookup_word_type;

   // cache model plus queue of lookups still owed by the block
   class lookup_scoreboard_type;
      bit                  line_valid [LINES];
      logic [BLK_W-1:0]    line_block [LINES];
      bit [1:0]            line_rank [LINES];
      logic [SETS_REG_W-1:0] sets_reg;
      logic [WAYS_REG_W-1:0] ways_reg;
      lookup_word_type     owed_lookups [$];
      int                  errors;

      function new();
         foreach (line_valid[i]) begin
            line_valid[i] = 0;
            line_block[i] = '0;
            line_rank[i]  = 0;
         end
         sets_reg = SETS_REG_RST;
         ways_reg = WAYS_REG_RST;
         errors   = 0;
      endfunction

      // zero acts as one, above the size saturates
      function int active_sets();
         if (sets_reg == 0) return 1;
         if (sets_reg > SETS) return SETS;
         return sets_reg;
      endfunction

      function int active_ways();
         if (ways_reg == 0) return 1;
         if (ways_reg > WAYS) return WAYS;
         return ways_reg;
      endfunction

      function void write_reg(logic idx, logic [31:0] value);
         if (idx == REG_SETS) sets_reg = value[SETS_REG_W-1:0];
         else ways_reg = value[WAYS_REG_W-1:0];
      endfunction

      // bump ranks below limit for valid in-use ways, saturating at the oldest rank
      function void age_set(int base, int nw, int limit);
         for (int w = 0; w < nw; w++) begin
            if (line_valid[base+w] && line_rank[base+w] < limit &&
                line_rank[base+w] < WAYS - 1)
               line_rank[base+w]++;
         end
      endfunction

      // predict the lookup for an accepted block number and update the model
      function void note_access(logic [BLK_W-1:0] blk);
         int nw;
         int base;
         int way;
         int oldest;
         bit found;
         bit empty;
         lookup_word_type res;
         nw    = active_ways();
         base  = (int'(blk) % active_sets()) * WAYS;
         way   = 0;
         found = 0;
         empty = 0;
         res   = '0;
         for (int w = 0; w < nw && !found; w++) begin
            if (line_valid[base+w] && line_block[base+w] == blk) begin
               found = 1;
               way   = w;
            end
         end
         if (found) begin
            res.hit = 1;
            age_set(base, nw, line_rank[base+way]);
            line_rank[base+way] = 0;
         end else begin
            for (int w = 0; w < nw && !empty; w++) begin
               if (!line_valid[base+w]) begin
                  empty = 1;
                  way   = w;
               end
            end
            // full set: lowest way with the oldest rank goes
            if (!empty) begin
               oldest = 0;
               way    = 0;
               for (int w = 0; w < nw; w++) begin
                  if (line_rank[base+w] > oldest) begin
                     oldest = line_rank[base+w];
                     way    = w;
                  end
               end
               res.evicted_valid = 1;
               res.evicted_block = line_block[base+way];
               line_valid[base+way] = 0;
            end
            age_set(base, nw, WAYS);
            line_valid[base+way] = 1;
            line_block[base+way] = blk;
            line_rank[base+way]  = 0;
         end
         res.way_used = way[1:0];
         owed_lookups = {owed_lookups, res};
      endfunction

      // compare a result word with the oldest prediction
      function void check_lookup(lookup_word_type got);
         lookup_word_type want;
         if (owed_lookups.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result word: hit %0d way %0d ev %0d blk %h",
                        got.hit, got.way_used, got.evicted_valid, got.evicted_block);
            return;
         end
         want = owed_lookups.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: expected hit %0d way %0d ev %0d blk %h, got %0d %0d %0d %h",
                        $time, want.hit, want.way_used, want.evicted_valid,
                        want.evicted_block, got.hit, got.way_used, got.evicted_valid,
                        got.evicted_block);
         end
      endfunction

      function int owed();
         return owed_lookups.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BLK_W-1:0]  req_block_number;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_hit;
   logic [1:0]        rsp_way_used;
   logic              rsp_evicted_valid;
   logic [BLK_W-1:0]  rsp_evicted_block;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   lookup_scoreboard_type sb = new();
   int                send_idle_pct;
   int                recv_idle_pct;

   set_assoc_lru_cache_lookup dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_block_number  (req_block_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_way_used      (rsp_way_used),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_block (rsp_evicted_block),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock
   always #10 clock = ~clock;

   // run limit
   initial begin
      #20_000_000;
      $display("set_assoc_lru_cache_lookup: mismatch");
      $finish;
   end

   // result side: random stall at the falling edge, sample at the rising edge
   initial begin
      lookup_word_type got;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.hit           = rsp_hit;
            got.way_used      = rsp_way_used;
            got.evicted_valid = rsp_evicted_valid;
            got.evicted_block = rsp_evicted_block;
            sb.check_lookup(got);
         end
      end
   end

   // register write: setup then access phase
   task automatic write_csr(logic idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // offer one word after a random gap; returns at the falling edge after accept
   task automatic send_block(logic [BLK_W-1:0] blk);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid        <= 1;
      req_block_number <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_access(blk);
      @(negedge clock);
   endtask

   // stop offering and wait for every owed lookup
   task automatic drain();
      req_valid <= 0;
      while (sb.owed() != 0) @(negedge clock);
   endtask

   task automatic set_config(int sets_val, int ways_val);
      drain();
      write_csr(REG_SETS, sets_val);
      write_csr(REG_WAYS, ways_val);
   endtask

   // fills, hits, evictions, hidden ways, zero and saturated counts
   task automatic run_directed();
      send_block(16'h0000);
      send_block(16'hFFFF);
      send_block(16'h0000);
      send_block(16'h0010);
      send_block(16'h0020);
      send_block(16'h0030);
      send_block(16'h0040);
      send_block(16'h0020);
      send_block(16'h0050);
      send_block(16'hAAA0);
      send_block(16'h5550);
      // ways beyond the count keep their lines
      set_config(16, 2);
      send_block(16'h0060);
      send_block(16'h0030);
      set_config(16, 4);
      send_block(16'h0050);
      send_block(16'h8000);
      // zero counts act as one
      set_config(0, 0);
      send_block(16'h1234);
      send_block(16'h1234);
      send_block(16'h4321);
      // counts above the size saturate
      set_config(31, 7);
      send_block(16'h7FFF);
      send_block(16'h0000);
      send_block(16'hFFFF);
   endtask

   // random words mostly drawn from a small pool so sets fill and evict
   task automatic run_random(int sets_val, int ways_val, int count);
      logic [BLK_W-1:0] pool [128];
      int pool_size;
      logic [BLK_W-1:0] blk;
      set_config(sets_val, ways_val);
      pool_size = sb.active_sets() * sb.active_ways() * 3 / 2 + 2;
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) blk = pool[$urandom_range(0, pool_size - 1)];
         else blk = $urandom;
         send_block(blk);
      end
   endtask

   // main sequence
   initial begin
      clock            = 0;
      reset            = 1;
      req_valid        = 0;
      req_block_number = '0;
      rsp_stall        = 0;
      psel             = 0;
      penable          = 0;
      pwrite           = 0;
      paddr            = '0;
      pwdata           = '0;
      send_idle_pct    = 30;
      recv_idle_pct    = 83;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      run_directed();
      run_random(1, 1, 85);
      run_random(31, 7, 85);
      run_random(0, 0, 85);
      run_random(3, 2, 85);
      send_idle_pct = 83;
      recv_idle_pct = 30;
      run_random(16, 4, 85);
      run_random(5, 3, 85);
      run_random(2, 4, 85);
      run_random(7, 1, 85);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(16, 2, 85);
      run_random(11, 4, 85);
      run_random(4, 3, 85);
      run_random(16, 4, 85);

      drain();
      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.owed() == 0)
         $display("set_assoc_lru_cache_lookup: match");
      else
         $display("set_assoc_lru_cache_lookup: mismatch");
      $finish;
   end

endmodule

/* set_assoc_lru_cache_lookup.f */
sv/salc_pkg.sv
sv/salc_mod.sv
sv/salc_dpath.sv
sv/salc_ctrl.sv
sv/set_assoc_lru_cache_lookup.sv
test/set_assoc_lru_cache_lookup_tb.sv
